// ===== src/gamepad_init_handshake_sequencer_defines.svh =====
// Assertion macros shared by the gamepad setup sequencer RTL.
// Included by files that check their own logic; needs nothing else.
`ifndef GAMEPAD_INIT_HANDSHAKE_SEQUENCER_DEFINES_SVH
`define GAMEPAD_INIT_HANDSHAKE_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define GIHS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every clock edge, reset included.
`define GIHS_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GIHS_ASSERT_RST(label, clk, rst, prop, msg)
`define GIHS_ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ===== src/gihs_pkg.sv =====
// Types, codes and constants of the gamepad setup sequencer.
// Used by the step logic and the top level.
package gihs_pkg;

   localparam logic [15:0] VENDOR_ID      = 16'h057e;
   localparam logic [15:0] PRODUCT_PAD    = 16'h2009;
   localparam logic [15:0] PRODUCT_GRIP   = 16'h200e;
   localparam logic [7:0]  REPORT_ID_FULL = 8'h30;
   localparam logic [7:0]  REPLY_CMD      = 8'h81;
   localparam logic [7:0]  REPLY_SUB      = 8'h21;
   localparam logic [7:0]  HEAD_PLAIN     = 8'h80;
   localparam logic [7:0]  HEAD_SUB       = 8'h01;
   localparam logic [6:0]  LEN_PLAIN      = 7'd2;
   localparam logic [6:0]  LEN_SUB        = 7'd64;

   // Plain command codes and subcommand ids.
   localparam logic [7:0]  CMD_MAC        = 8'h01;
   localparam logic [7:0]  CMD_HANDSHAKE  = 8'h02;
   localparam logic [7:0]  CMD_BAUDRATE   = 8'h03;
   localparam logic [7:0]  CMD_NO_TIMEOUT = 8'h04;
   localparam logic [7:0]  SUB_NO_TIMEOUT = 8'h33;
   localparam logic [7:0]  SUB_PLAYER_LED = 8'h30;
   localparam logic [7:0]  SUB_HOME_LED   = 8'h38;
   localparam logic [7:0]  SUB_RPT_MODE   = 8'h03;
   localparam logic [31:0] ARG_HOME_LED   = 32'h00f0_f001;
   localparam logic [31:0] ARG_RPT_MODE   = 32'h0000_0030;

   // Protocol states: each stage has an OUT, an IN and a receive state.
   localparam logic [4:0] ST_CONNECTED = 5'd0;
   localparam logic [4:0] ST_MAC_OUT   = 5'd1;
   localparam logic [4:0] ST_MAC_IN    = 5'd2;
   localparam logic [4:0] ST_MAC_RX    = 5'd3;
   localparam logic [4:0] ST_HS_OUT    = 5'd4;
   localparam logic [4:0] ST_HS_IN     = 5'd5;
   localparam logic [4:0] ST_HS_RX     = 5'd6;
   localparam logic [4:0] ST_BAUD_OUT  = 5'd7;
   localparam logic [4:0] ST_BAUD_IN   = 5'd8;
   localparam logic [4:0] ST_BAUD_RX   = 5'd9;
   localparam logic [4:0] ST_HS2_OUT   = 5'd10;
   localparam logic [4:0] ST_HS2_IN    = 5'd11;
   localparam logic [4:0] ST_HS2_RX    = 5'd12;
   localparam logic [4:0] ST_NTO_OUT   = 5'd13;
   localparam logic [4:0] ST_NTO_IN    = 5'd14;
   localparam logic [4:0] ST_NTO_RX    = 5'd15;
   localparam logic [4:0] ST_NTO2_OUT  = 5'd16;
   localparam logic [4:0] ST_NTO2_IN   = 5'd17;
   localparam logic [4:0] ST_NTO2_RX   = 5'd18;
   localparam logic [4:0] ST_PLED_OUT  = 5'd19;
   localparam logic [4:0] ST_PLED_IN   = 5'd20;
   localparam logic [4:0] ST_PLED_RX   = 5'd21;
   localparam logic [4:0] ST_HLED_OUT  = 5'd22;
   localparam logic [4:0] ST_HLED_IN   = 5'd23;
   localparam logic [4:0] ST_HLED_RX   = 5'd24;
   localparam logic [4:0] ST_RMODE_OUT = 5'd25;
   localparam logic [4:0] ST_RMODE_IN  = 5'd26;
   localparam logic [4:0] ST_RMODE_RX  = 5'd27;
   localparam logic [4:0] ST_INIT      = 5'd28;

   typedef enum logic [1:0] {
      OP_CONNECT = 2'd0,
      OP_POLL    = 2'd1,
      OP_PACKET  = 2'd2,
      OP_NAK     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_SEND_OUT  = 3'd1,
      ACT_REQ_IN    = 3'd2,
      ACT_FORWARD   = 3'd3,
      ACT_ABSORBED  = 3'd4,
      ACT_UNCLAIMED = 3'd5
   } action_type;

   typedef struct packed {
      op_type      operation;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [7:0]  rx_byte0;
      logic [7:0]  rx_byte1;
      logic [7:0]  rx_byte3;
      logic [7:0]  rx_byte4;
      logic [7:0]  rx_byte14;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  endpoint;
      logic [6:0]  out_length;
      logic [7:0]  head_byte;
      logic [7:0]  second_byte;
      logic [7:0]  subcommand_id;
      logic [31:0] argument_bytes;
      logic [7:0]  merged_byte3;
      logic [7:0]  merged_byte4;
      logic        initialized;
   } rsp_type;

   typedef struct packed {
      logic       device_claimed;
      logic       is_charging_grip;
      logic [4:0] protocol_state;
      logic       second_half_phase;
      logic [7:0] held_byte3;
      logic [7:0] held_byte4;
      logic [7:0] packet_counter;
   } seq_state_type;

endpackage

// ===== src/gihs_req_if.sv =====
// Input channel of the gamepad setup sequencer: valid, ready and one event.
// Depends on nothing else.
interface gihs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] vendor_id;
   logic [15:0] product_id;
   logic [7:0]  rx_byte0;
   logic [7:0]  rx_byte1;
   logic [7:0]  rx_byte3;
   logic [7:0]  rx_byte4;
   logic [7:0]  rx_byte14;

   modport source (
      output valid, operation, vendor_id, product_id,
      output rx_byte0, rx_byte1, rx_byte3, rx_byte4, rx_byte14,
      input  ready
   );
   modport sink (
      input  valid, operation, vendor_id, product_id,
      input  rx_byte0, rx_byte1, rx_byte3, rx_byte4, rx_byte14,
      output ready
   );
endinterface

// ===== src/gihs_rsp_if.sv =====
// Result channel of the gamepad setup sequencer: valid, ready and one result.
// Depends on nothing else.
interface gihs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [1:0]  endpoint;
   logic [6:0]  out_length;
   logic [7:0]  head_byte;
   logic [7:0]  second_byte;
   logic [7:0]  subcommand_id;
   logic [31:0] argument_bytes;
   logic [7:0]  merged_byte3;
   logic [7:0]  merged_byte4;
   logic        initialized;

   modport source (
      output valid, action, endpoint, out_length, head_byte, second_byte,
      output subcommand_id, argument_bytes, merged_byte3, merged_byte4, initialized,
      input  ready
   );
   modport sink (
      input  valid, action, endpoint, out_length, head_byte, second_byte,
      input  subcommand_id, argument_bytes, merged_byte3, merged_byte4, initialized,
      output ready
   );
endinterface

// ===== src/gihs_step.sv =====
// Next-state and result logic for one event of the setup sequencer.
// Depends on gihs_pkg.
module gihs_step (
   input  gihs_pkg::req_type       req,
   input  gihs_pkg::seq_state_type state_cur,
   input  logic                    port_index,
   output gihs_pkg::seq_state_type state_nxt,
   output gihs_pkg::rsp_type       rsp
);
   import gihs_pkg::*;

   logic [4:0] state_inc;
   logic [4:0] state_dec;
   logic       ack_waits;
   logic       ack_ok;
   logic       cmd_reply;
   logic       sub_reply;

   assign state_inc = state_cur.protocol_state + 5'd1;
   assign state_dec = (state_cur.protocol_state == ST_CONNECTED) ?
                      ST_CONNECTED : state_cur.protocol_state - 5'd1;
   assign cmd_reply = (req.rx_byte0 == REPLY_CMD);
   assign sub_reply = (req.rx_byte0 == REPLY_SUB);

   // Expected acknowledge of each receive state.
   always_comb begin
      ack_waits = 1'b1;
      ack_ok    = 1'b0;
      unique case (state_cur.protocol_state)
         ST_MAC_RX:                ack_ok = cmd_reply && (req.rx_byte1 == CMD_MAC);
         ST_HS_RX, ST_HS2_RX:      ack_ok = cmd_reply && (req.rx_byte1 == CMD_HANDSHAKE);
         ST_BAUD_RX:               ack_ok = cmd_reply && (req.rx_byte1 == CMD_BAUDRATE);
         ST_NTO_RX:                ack_ok = 1'b1;
         ST_NTO2_RX:               ack_ok = sub_reply && (req.rx_byte14 == SUB_NO_TIMEOUT);
         ST_PLED_RX:               ack_ok = sub_reply && (req.rx_byte14 == SUB_PLAYER_LED);
         ST_HLED_RX:               ack_ok = sub_reply && (req.rx_byte14 == SUB_HOME_LED);
         ST_RMODE_RX:              ack_ok = sub_reply && (req.rx_byte14 == SUB_RPT_MODE);
         default:                  ack_waits = 1'b0;
      endcase
   end

   always_comb begin
      state_nxt = state_cur;
      rsp       = '0;
      rsp.action   = ACT_NONE;
      rsp.endpoint = state_cur.second_half_phase ? 2'd2 : 2'd1;

      if (req.operation == OP_CONNECT) begin
         if (req.vendor_id == VENDOR_ID &&
             (req.product_id == PRODUCT_PAD || req.product_id == PRODUCT_GRIP)) begin
            state_nxt.device_claimed   = 1'b1;
            state_nxt.is_charging_grip = (req.product_id == PRODUCT_GRIP);
            state_nxt.protocol_state   = ST_CONNECTED;
         end else begin
            state_nxt.device_claimed = 1'b0;
            rsp.action               = ACT_UNCLAIMED;
         end
      end else if (!state_cur.device_claimed) begin
         rsp.action = ACT_UNCLAIMED;
      end else if (req.operation == OP_POLL) begin
         unique case (state_cur.protocol_state) inside
            ST_CONNECTED: begin
               state_nxt.second_half_phase = 1'b0;
               state_nxt.held_byte3        = '0;
               state_nxt.held_byte4        = '0;
               state_nxt.protocol_state    = ST_MAC_OUT;
            end
            ST_INIT: begin
               rsp.action = ACT_REQ_IN;
               if (state_cur.is_charging_grip) begin
                  state_nxt.second_half_phase = ~state_cur.second_half_phase;
               end
            end
            ST_MAC_IN, ST_HS_IN, ST_BAUD_IN, ST_HS2_IN, ST_NTO_IN, ST_NTO2_IN,
            ST_PLED_IN, ST_HLED_IN, ST_RMODE_IN: begin
               rsp.action               = ACT_REQ_IN;
               state_nxt.protocol_state = state_inc;
            end
            ST_MAC_OUT, ST_HS_OUT, ST_HS2_OUT, ST_BAUD_OUT, ST_NTO_OUT: begin
               rsp.action               = ACT_SEND_OUT;
               rsp.out_length           = LEN_PLAIN;
               rsp.head_byte            = HEAD_PLAIN;
               state_nxt.protocol_state = state_inc;
               case (state_cur.protocol_state)
                  ST_MAC_OUT:  rsp.second_byte = CMD_MAC;
                  ST_BAUD_OUT: rsp.second_byte = CMD_BAUDRATE;
                  ST_NTO_OUT:  rsp.second_byte = CMD_NO_TIMEOUT;
                  default:     rsp.second_byte = CMD_HANDSHAKE;
               endcase
            end
            ST_NTO2_OUT, ST_PLED_OUT, ST_HLED_OUT, ST_RMODE_OUT: begin
               rsp.action               = ACT_SEND_OUT;
               rsp.out_length           = LEN_SUB;
               rsp.head_byte            = HEAD_SUB;
               rsp.second_byte          = state_cur.packet_counter;
               state_nxt.packet_counter = state_cur.packet_counter + 8'd1;
               state_nxt.protocol_state = state_inc;
               case (state_cur.protocol_state)
                  ST_NTO2_OUT: begin
                     rsp.subcommand_id = SUB_NO_TIMEOUT;
                  end
                  ST_PLED_OUT: begin
                     rsp.subcommand_id  = SUB_PLAYER_LED;
                     rsp.argument_bytes = 32'(port_index) + 32'd1;
                  end
                  ST_HLED_OUT: begin
                     rsp.subcommand_id  = SUB_HOME_LED;
                     rsp.argument_bytes = ARG_HOME_LED;
                  end
                  default: begin
                     rsp.subcommand_id  = SUB_RPT_MODE;
                     rsp.argument_bytes = ARG_RPT_MODE;
                  end
               endcase
            end
            // Receive states and the unused codes above the initialized state.
            default: ;
         endcase
      end else if (req.operation == OP_NAK) begin
         if (state_cur.protocol_state != ST_INIT) begin
            state_nxt.protocol_state = state_dec;
         end
      end else if (state_cur.protocol_state == ST_INIT &&
                   req.rx_byte0 == REPORT_ID_FULL) begin
         if (state_cur.second_half_phase) begin
            state_nxt.held_byte3 = req.rx_byte3;
            state_nxt.held_byte4 = req.rx_byte4;
            rsp.action           = ACT_ABSORBED;
         end else begin
            rsp.action       = ACT_FORWARD;
            rsp.merged_byte3 = req.rx_byte3 | state_cur.held_byte3;
            rsp.merged_byte4 = req.rx_byte4 | state_cur.held_byte4;
         end
      end else if (ack_waits) begin
         if (!ack_ok) begin
            state_nxt.protocol_state = state_dec;
         end else if (state_inc == ST_INIT && state_cur.is_charging_grip &&
                      !state_cur.second_half_phase) begin
            // The grip repeats the whole setup for its second half.
            state_nxt.second_half_phase = 1'b1;
            state_nxt.protocol_state    = ST_MAC_OUT;
         end else begin
            state_nxt.protocol_state = state_inc;
         end
      end

      rsp.initialized = (state_nxt.protocol_state == ST_INIT);
   end
endmodule

// ===== src/gamepad_init_handshake_sequencer.sv =====
// Top level of the gamepad setup sequencer: input register, step logic,
// sequencer state and result register. Depends on gihs_pkg, gihs_req_if,
// gihs_rsp_if, gihs_step and gamepad_init_handshake_sequencer_defines.svh.
//
//   channel   direction  handshake        contents
//   req_chan  in         valid / ready    event code, descriptor ids, packet bytes
//   rsp_chan  out        valid / ready    action, OUT command fields, merged report
//   csr_*     in         write enable     port index (player LED pattern)
//
// Every event yields one result: the input register holds the event, then the
// step logic writes the result register and the state.
// One event per cycle is taken while the result side keeps up; a stall holds
// the result register, then the input register, then drops req_chan.ready.
// Reset clears the state, the port index and both valid flags at once.
`include "gamepad_init_handshake_sequencer_defines.svh"

module gamepad_init_handshake_sequencer (
   input  logic              clock,
   input  logic              reset,
   gihs_req_if.sink          req_chan,
   gihs_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import gihs_pkg::*;

   req_type       req_ff;
   req_type       req_in;
   logic          req_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          port_index_ff;
   logic          rsp_free;
   logic          step_go;
   logic          req_take;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign step_go  = req_valid_ff && rsp_free;
   assign req_chan.ready = !req_valid_ff || step_go;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      req_in.operation  = op_type'(req_chan.operation);
      req_in.vendor_id  = req_chan.vendor_id;
      req_in.product_id = req_chan.product_id;
      req_in.rx_byte0   = req_chan.rx_byte0;
      req_in.rx_byte1   = req_chan.rx_byte1;
      req_in.rx_byte3   = req_chan.rx_byte3;
      req_in.rx_byte4   = req_chan.rx_byte4;
      req_in.rx_byte14  = req_chan.rx_byte14;
   end

   gihs_step u_step (
      .req        (req_ff),
      .state_cur  (state_ff),
      .port_index (port_index_ff),
      .state_nxt  (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         port_index_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (step_go) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            port_index_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (step_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.action         = rsp_ff.action;
   assign rsp_chan.endpoint       = rsp_ff.endpoint;
   assign rsp_chan.out_length     = rsp_ff.out_length;
   assign rsp_chan.head_byte      = rsp_ff.head_byte;
   assign rsp_chan.second_byte    = rsp_ff.second_byte;
   assign rsp_chan.subcommand_id  = rsp_ff.subcommand_id;
   assign rsp_chan.argument_bytes = rsp_ff.argument_bytes;
   assign rsp_chan.merged_byte3   = rsp_ff.merged_byte3;
   assign rsp_chan.merged_byte4   = rsp_ff.merged_byte4;
   assign rsp_chan.initialized    = rsp_ff.initialized;

   // A pending transaction always reflects the state its own event left behind.
   `GIHS_ASSERT_RST(a_init_matches_state, clock, reset,
      rsp_valid_ff |-> (rsp_ff.initialized == (state_ff.protocol_state == ST_INIT)),
      "initialized flag disagrees with the protocol state")
   `GIHS_ASSERT_RST(a_transfer_needs_claim, clock, reset,
      rsp_valid_ff && (rsp_ff.action == ACT_SEND_OUT || rsp_ff.action == ACT_REQ_IN)
         |-> state_ff.device_claimed,
      "transfer issued for an unclaimed device")
   `GIHS_ASSERT_RST(a_counter_on_subcommand, clock, reset,
      (state_ff.packet_counter != $past(state_ff.packet_counter))
         |-> (rsp_valid_ff && rsp_ff.out_length == LEN_SUB),
      "packet counter moved without a subcommand packet")
endmodule
